// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define AVG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define AVG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== src/avg_pkg.sv =====
// Shared types and constants of the decimating averager.
// No dependencies.
package avg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int AVG_W    = 16;
  localparam int CH_W     = 4;
  localparam int MAX_CH   = 16;
  localparam int CCNT_W   = 5;
  localparam int FCT_W    = 7;
  localparam int MAX_FCT  = 64;
  localparam int PHASE_W  = 6;
  localparam int SUM_W    = 22;
  localparam int REM_W    = FCT_W;
  localparam int STEP_W   = $clog2(SUM_W + 1);
  localparam int Q_DEPTH  = 2;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_SUPERSAMPLE   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_DIV  = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic              en;
    reg_idx_t          idx;
    logic [APB_DW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic             bypass;
    logic [SUM_W-1:0] dividend;
    logic [FCT_W-1:0] divisor;
    logic [CH_W-1:0]  chan;
  } q_entry_t;

endpackage

// ===== src/avg_front.sv =====
// Front end: configuration registers, channel/sweep tracking and per-channel sums.
// Emits one request per result into the queue. Depends on avg_pkg.
module avg_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  avg_pkg::cfg_wr_t                  cfg_wr,
  output logic [avg_pkg::APB_DW-1:0]        cfg_rd_chan,
  output logic [avg_pkg::APB_DW-1:0]        cfg_rd_fct,
  input  logic                              push,
  input  logic [avg_pkg::SAMPLE_W-1:0]      sample,
  input  logic                              q_full,
  output logic                              q_push,
  output avg_pkg::q_entry_t                 q_entry
);
  import avg_pkg::*;

  logic [CCNT_W-1:0]  ccnt_r;
  logic [FCT_W-1:0]   fct_r;
  logic [CH_W-1:0]    pos_r;
  logic [PHASE_W-1:0] phase_r;
  logic [SUM_W-1:0]   sums_r [MAX_CH];

  logic [CCNT_W-1:0]  nch_eff;
  logic [FCT_W-1:0]   fct_eff;
  logic [CH_W-1:0]    pos_eff;
  logic [PHASE_W-1:0] phase_eff;
  logic [CCNT_W-1:0]  pos_inc;
  logic [FCT_W-1:0]   phase_inc;
  logic               wrap;
  logic               pass;
  logic               last;
  logic               accept;
  logic [SUM_W-1:0]   sum_nxt;
  logic [CH_W-1:0]    pos_nxt;
  logic [PHASE_W-1:0] phase_nxt;

  always_comb begin
    if (ccnt_r == '0) begin
      nch_eff = CCNT_W'(1);
    end else if (ccnt_r > CCNT_W'(MAX_CH)) begin
      nch_eff = CCNT_W'(MAX_CH);
    end else begin
      nch_eff = ccnt_r;
    end
    if (fct_r == '0) begin
      fct_eff = FCT_W'(1);
    end else if (fct_r > FCT_W'(MAX_FCT)) begin
      fct_eff = FCT_W'(MAX_FCT);
    end else begin
      fct_eff = fct_r;
    end
  end

  assign pos_eff   = ({1'b0, pos_r} >= nch_eff) ? '0 : pos_r;
  assign pass      = (fct_eff == FCT_W'(1));
  assign phase_eff = ({1'b0, phase_r} >= fct_eff) ? '0 : phase_r;
  assign last      = ({1'b0, phase_eff} == (fct_eff - FCT_W'(1)));
  assign accept    = push && !q_full;
  assign sum_nxt   = sums_r[pos_eff] + SUM_W'(sample);
  assign pos_inc   = {1'b0, pos_eff} + CCNT_W'(1);
  assign wrap      = (pos_inc >= nch_eff);
  assign phase_inc = {1'b0, phase_eff} + FCT_W'(1);

  always_comb begin
    pos_nxt   = wrap ? '0 : pos_inc[CH_W-1:0];
    phase_nxt = phase_r;
    if (pass) begin
      phase_nxt = '0;
    end else if (wrap) begin
      phase_nxt = (phase_inc >= fct_eff) ? '0 : phase_inc[PHASE_W-1:0];
    end else begin
      phase_nxt = phase_eff;
    end
  end

  assign q_push           = accept && (pass || last);
  assign q_entry.bypass   = pass;
  assign q_entry.dividend = pass ? SUM_W'(sample) : sum_nxt;
  assign q_entry.divisor  = fct_eff;
  assign q_entry.chan     = pos_eff;

  assign cfg_rd_chan = APB_DW'(ccnt_r);
  assign cfg_rd_fct  = APB_DW'(fct_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r  <= CCNT_W'(1);
      fct_r   <= FCT_W'(1);
      pos_r   <= '0;
      phase_r <= '0;
      for (int i = 0; i < MAX_CH; i++) begin
        sums_r[i] <= '0;
      end
    end else if (cfg_wr.en) begin
      if (cfg_wr.idx == REG_CHANNEL_COUNT) begin
        ccnt_r <= cfg_wr.data[CCNT_W-1:0];
      end else begin
        fct_r <= cfg_wr.data[FCT_W-1:0];
      end
      pos_r   <= '0;
      phase_r <= '0;
      for (int i = 0; i < MAX_CH; i++) begin
        sums_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      if (!pass) begin
        sums_r[pos_eff] <= last ? '0 : sum_nxt;
      end
    end
  end

endmodule

// ===== src/avg_queue.sv =====
// Short request queue between the front end and the divider.
// Depends on avg_pkg.
module avg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  avg_pkg::q_entry_t  wr_data,
  output logic               full,
  input  logic               rd_en,
  output avg_pkg::q_entry_t  rd_data,
  output logic               empty
);
  import avg_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/avg_back.sv =====
// Back end: restoring divider, one quotient bit per cycle, and the result register.
// Depends on avg_pkg.
module avg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  avg_pkg::q_entry_t             q_entry,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [avg_pkg::AVG_W-1:0]     out_value,
  output logic [avg_pkg::CH_W-1:0]      out_chan
);
  import avg_pkg::*;

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [SUM_W-1:0]   quo_r;
  logic [REM_W-1:0]   rem_r;
  logic [FCT_W-1:0]   div_r;
  logic [CH_W-1:0]    chan_r;
  logic [STEP_W-1:0]  step_r;
  logic               out_vld_r;
  logic [AVG_W-1:0]   res_val_r;
  logic [CH_W-1:0]    res_chan_r;

  logic               finish;
  logic [REM_W:0]     shifted;
  logic [REM_W:0]     diff;
  logic               ge;
  logic [REM_W-1:0]   rem_nxt;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign ge      = (shifted >= {1'b0, div_r});
  assign diff    = shifted - {1'b0, div_r};
  assign rem_nxt = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (finish) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    finish = 1'b0;
    case (state_r)
      BK_IDLE: q_pop  = !q_empty;
      BK_DIV:  finish = (step_r == '0) && (!out_vld_r || out_pop);
      default: begin
        q_pop  = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      step_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        step_r <= q_entry.bypass ? '0 : STEP_W'(SUM_W);
      end else if (state_r == BK_DIV && step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
      end
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo_r  <= q_entry.dividend;
      rem_r  <= '0;
      div_r  <= q_entry.divisor;
      chan_r <= q_entry.chan;
    end else if (state_r == BK_DIV && step_r != '0) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
    if (finish) begin
      res_val_r  <= quo_r[AVG_W-1:0];
      res_chan_r <= chan_r;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_value = res_val_r;
  assign out_chan  = res_chan_r;

endmodule

// ===== src/multichannel_decimating_averager.sv =====
// Usage notes
// Input channel: a converter sample is taken when push is high and full is low.
// Samples come round-robin, channel 0 first, over channel_count channels.
// Result channel: while empty is low, out_average_value and out_channel_index
// hold the oldest result; pop with empty low takes it.
// Config: APB-style writes; channel_count at 0x0, supersample_factor at 0x4.
// Any write clears all sums and restarts the sweep at channel 0.
// With a factor of 1 each sample is passed through the queue to the divider
// with no divide steps, and the divider takes one request at a time.
// Otherwise the last sweep of each group gives one result per channel;
// each takes load, 22 restoring divide steps and result write, and the
// result write waits while the previous result has not been popped.
// Sweeps without results are taken at one sample per cycle while full is low.
// A 2-entry queue decouples the front from the divider, so samples are
// taken while a result waits; full rises when queue and divider are busy.
// Reset: channel_count and supersample_factor become 1, sums clear,
// queue and result register empty.
// Depends on avg_pkg, avg_front, avg_queue, avg_back.
module multichannel_decimating_averager (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [avg_pkg::SAMPLE_W-1:0]    in_sample_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [avg_pkg::AVG_W-1:0]       out_average_value,
  output logic [avg_pkg::CH_W-1:0]        out_channel_index,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [avg_pkg::APB_AW-1:0]      paddr,
  input  logic [avg_pkg::APB_DW-1:0]      pwdata,
  output logic [avg_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import avg_pkg::*;

  cfg_wr_t           cfg_wr;
  logic [APB_DW-1:0] rd_chan;
  logic [APB_DW-1:0] rd_fct;
  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  q_entry_t          q_wr;
  q_entry_t          q_rd;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = reg_idx_t'(paddr[2]);
  assign cfg_wr.data = pwdata;
  assign prdata      = (reg_idx_t'(paddr[2]) == REG_CHANNEL_COUNT) ? rd_chan : rd_fct;
  assign full        = q_full;

  avg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .cfg_rd_chan (rd_chan),
    .cfg_rd_fct  (rd_fct),
    .push        (push),
    .sample      (in_sample_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_wr)
  );

  avg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  avg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_rd),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_value (out_average_value),
    .out_chan  (out_channel_index)
  );

endmodule

// ===== src/avg_checker.sv =====
// Port-level checks for the decimating averager, bound to the top level.
// Depends on avg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module avg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [avg_pkg::AVG_W-1:0]    out_average_value,
  input logic [avg_pkg::CH_W-1:0]     out_channel_index,
  input logic                         pready
);

  `AVG_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> empty && !full)
  `AVG_ASSERT(a_result_holds, clk, rst_n, !empty && !pop |=> !empty && $stable(out_average_value) && $stable(out_channel_index))
  `AVG_ASSERT(a_full_after_push, clk, rst_n, $rose(full) |-> $past(push))
  `AVG_ASSERT(a_ready_high, clk, rst_n, pready)

endmodule

bind multichannel_decimating_averager avg_checker u_avg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .push              (push),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_average_value (out_average_value),
  .out_channel_index (out_channel_index),
  .pready            (pready)
);
